// File: hw/rtl/pse_pkg.sv
package pse_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int KIND_W     = 3;
  localparam int LEN_W      = 5;
  localparam int OUT_IDX_W  = 4;
  localparam int CNT_W      = 16;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN  = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_HOLD       = 3'd0,
    KIND_LEX_NEXT   = 3'd1,
    KIND_LEX_PREV   = 3'd2,
    KIND_ROT_RIGHT  = 3'd3,
    KIND_ROT_LEFT   = 3'd4,
    KIND_REVERSE    = 3'd5,
    KIND_SWAP_PAIRS = 3'd6,
    KIND_SKIP       = 3'd7
  } pse_kind_t;

  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_PLAN     = 4'd1,
    S_SW_RD    = 4'd2,
    S_SW_WA    = 4'd3,
    S_SW_WB    = 4'd4,
    S_LX_RD    = 4'd5,
    S_LX_CMP   = 4'd6,
    S_EMIT_RD0 = 4'd7,
    S_EMIT     = 4'd8
  } pse_state_t;

  // Swap schedule followed by the planner
  typedef enum logic [2:0] {
    MD_REV       = 3'd0,
    MD_ROT_RIGHT = 3'd1,
    MD_ROT_LEFT  = 3'd2,
    MD_PAIRS     = 3'd3,
    MD_SKIP      = 3'd4,
    MD_LEX_I     = 3'd5,
    MD_LEX_J     = 3'd6
  } pse_mode_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } pse_mem_ctl_t;

endpackage

// File: hw/rtl/pse_perm_store.sv
module pse_perm_store
  import pse_pkg::*;
#(
  parameter int MAX_LEN = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pse_mem_ctl_t               ctl,
  input  logic [$clog2(MAX_LEN)-1:0] rd_addr_a,
  input  logic [$clog2(MAX_LEN)-1:0] rd_addr_b,
  input  logic [$clog2(MAX_LEN)-1:0] wr_addr,
  input  logic [$clog2(MAX_LEN)-1:0] wr_data,
  output logic [$clog2(MAX_LEN)-1:0] rd_data_a,
  output logic [$clog2(MAX_LEN)-1:0] rd_data_b
);

  localparam int AW = $clog2(MAX_LEN);

  logic [AW-1:0]      mem_r [MAX_LEN];
  logic [MAX_LEN-1:0] vld_r;
  logic [AW-1:0]      rd_data_a_r;
  logic [AW-1:0]      rd_data_b_r;

  // An entry never written since the last clear reads as its own index
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_a_r <= vld_r[rd_addr_a] ? mem_r[rd_addr_a] : rd_addr_a;
      rd_data_b_r <= vld_r[rd_addr_b] ? mem_r[rd_addr_b] : rd_addr_b;
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

// File: hw/rtl/permutation_step_engine_top.sv
// Permutation step engine: keeps an arrangement of the indices 0 .. n-1 in a small
// dual-read, single-write store and a 16-bit step counter. Each input transfer with
// restart low applies the configured rule (hold, lexicographic next/previous with
// wrap, rotate right/left, reverse, swap pairs, skip) and then streams the whole
// arrangement, one element per output transfer, last_element marking the final one;
// restart high returns to ascending order with counter zero and streams that. A
// write to the kind or length register also restarts, without output. The rule runs
// as a sequence of swaps and compares on one shared compare/swap unit: a swap is
// plan, read both, then write each back through the single write port (the swap that
// ends a successor search skips the plan step); a compare is read, then compare; a
// final plan step closes the schedule. Streaming reads the first element ahead, then
// loads one element per cycle while the output is not stalled. in_stall is high from
// acceptance until the last element has been loaded into the output register.
module permutation_step_engine_top
  import pse_pkg::*;
#(
  parameter int MAX_LEN = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_restart,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_IDX_W-1:0]  out_position,
  output logic [OUT_IDX_W-1:0]  out_element_value,
  output logic                  out_last_element,
  output logic [CNT_W-1:0]      out_step_count
);

  // AW: store address / element width; IW: loop indices, which may run past n
  localparam int AW  = $clog2(MAX_LEN);
  localparam int IW  = $clog2(MAX_LEN + 2);
  localparam int CW  = (IW > LEN_W) ? IW : LEN_W;
  localparam int EXW = (AW > OUT_IDX_W) ? AW : OUT_IDX_W;
  localparam int PXW = (IW > OUT_IDX_W) ? IW : OUT_IDX_W;

  pse_state_t state_r, state_nxt;
  pse_mode_t  mode_r, mode_nxt;
  pse_kind_t  kind_r, kind_nxt;

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0]    n_r, n_nxt;
  logic [IW-1:0]    lo_r, lo_nxt;
  logic [IW-1:0]    hi_r, hi_nxt;
  logic [IW-1:0]    k_r, k_nxt;
  logic [AW-1:0]    sa_r, sa_nxt;
  logic [AW-1:0]    sb_r, sb_nxt;
  logic             dir_r, dir_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0] out_pos_r, out_pos_nxt;
  logic [OUT_IDX_W-1:0] out_elem_r, out_elem_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [CNT_W-1:0]     out_cnt_r, out_cnt_nxt;

  pse_mem_ctl_t mem_ctl;
  logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr, wr_data;
  logic [AW-1:0] rd_data_a, rd_data_b;

  logic          in_fire;
  logic          out_load;
  logic          last_now;
  logic          cmp_hit;
  logic [CW-1:0] len_ext;
  logic [IW-1:0] n_calc;
  logic [IW-1:0] lim;

  logic          plan_go;
  logic [AW-1:0] plan_a, plan_b;
  logic [IW-1:0] plan_lo, plan_hi;

  logic [EXW-1:0] elem_wide;
  logic [PXW-1:0] pos_wide;

  pse_perm_store #(
    .MAX_LEN (MAX_LEN)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mem_ctl),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign last_now = (k_r == n_r - IW'(1));

  // Effective length: zero counts as one, anything above MAX_LEN saturates
  assign len_ext = CW'(len_r);
  assign n_calc  = (len_r == '0)               ? IW'(1)       :
                   (len_ext > CW'(MAX_LEN))    ? IW'(MAX_LEN) : IW'(len_ext);

  // Pair rules stop at the largest even count not above n
  assign lim = n_r[0] ? (n_r - IW'(1)) : n_r;

  // Shared compare: next looks for an ascent, previous for a descent
  assign cmp_hit = dir_r ? (rd_data_a < rd_data_b) : (rd_data_a > rd_data_b);

  // Swap planner: pick the next pair for the active schedule, or finish
  always_comb begin
    plan_go = 1'b0;
    plan_a  = '0;
    plan_b  = '0;
    plan_lo = lo_r;
    plan_hi = hi_r;
    unique case (mode_r)
      MD_REV: begin
        if (lo_r + IW'(1) < hi_r) begin
          plan_go = 1'b1;
          plan_a  = AW'(lo_r);
          plan_b  = AW'(hi_r - IW'(1));
          plan_lo = lo_r + IW'(1);
          plan_hi = hi_r - IW'(1);
        end
      end
      MD_ROT_RIGHT: begin
        if (hi_r != '0) begin
          plan_go = 1'b1;
          plan_a  = AW'(hi_r);
          plan_b  = AW'(hi_r - IW'(1));
          plan_hi = hi_r - IW'(1);
        end
      end
      MD_ROT_LEFT: begin
        if (lo_r + IW'(1) < n_r) begin
          plan_go = 1'b1;
          plan_a  = AW'(lo_r);
          plan_b  = AW'(lo_r + IW'(1));
          plan_lo = lo_r + IW'(1);
        end
      end
      MD_PAIRS, MD_SKIP: begin
        if (lo_r < lim) begin
          plan_go = 1'b1;
          plan_a  = AW'(lo_r);
          // skip wraps the partner of the last slot to index 0
          plan_b  = ((mode_r == MD_SKIP) && (lo_r + IW'(1) == n_r)) ? '0
                                                                    : AW'(lo_r + IW'(1));
          plan_lo = lo_r + IW'(2);
        end
      end
      default: begin
        plan_go = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_restart) begin
            state_nxt = S_EMIT_RD0;
          end else begin
            unique case (kind_r)
              KIND_HOLD: begin
                state_nxt = S_EMIT_RD0;
              end
              KIND_LEX_NEXT, KIND_LEX_PREV: begin
                state_nxt = (n_calc < IW'(2)) ? S_EMIT_RD0 : S_LX_RD;
              end
              default: begin
                state_nxt = S_PLAN;
              end
            endcase
          end
        end
      end
      S_PLAN:     state_nxt = plan_go ? S_SW_RD : S_EMIT_RD0;
      S_SW_RD:    state_nxt = S_SW_WA;
      S_SW_WA:    state_nxt = S_SW_WB;
      S_SW_WB:    state_nxt = S_PLAN;
      S_LX_RD:    state_nxt = S_LX_CMP;
      S_LX_CMP: begin
        if ((mode_r == MD_LEX_J) && cmp_hit) begin
          state_nxt = S_SW_RD;
        end else if ((mode_r == MD_LEX_I) && !cmp_hit && (hi_r == IW'(1))) begin
          state_nxt = S_PLAN;
        end else begin
          state_nxt = S_LX_RD;
        end
      end
      S_EMIT_RD0: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_load && last_now) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath, store control and outputs
  always_comb begin
    mode_nxt  = mode_r;
    kind_nxt  = kind_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    k_nxt     = k_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    dir_nxt   = dir_r;
    mem_ctl   = '0;
    rd_addr_a = '0;
    rd_addr_b = '0;
    wr_addr   = sa_r;
    wr_data   = rd_data_b;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          n_nxt   = n_calc;
          dir_nxt = (kind_r == KIND_LEX_NEXT);
          if (in_restart) begin
            mem_ctl.clear = 1'b1;
            cnt_nxt       = '0;
          end else begin
            // previous leaves the counter alone
            if (kind_r != KIND_LEX_PREV) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
            unique case (kind_r)
              KIND_LEX_NEXT, KIND_LEX_PREV: begin
                mode_nxt = MD_LEX_I;
                hi_nxt   = n_calc - IW'(1);
              end
              KIND_ROT_RIGHT: begin
                mode_nxt = MD_ROT_RIGHT;
                hi_nxt   = n_calc - IW'(1);
              end
              KIND_ROT_LEFT: begin
                mode_nxt = MD_ROT_LEFT;
                lo_nxt   = '0;
              end
              KIND_REVERSE: begin
                mode_nxt = MD_REV;
                lo_nxt   = '0;
                hi_nxt   = n_calc;
              end
              KIND_SWAP_PAIRS: begin
                mode_nxt = MD_PAIRS;
                lo_nxt   = '0;
              end
              KIND_SKIP: begin
                // start at the parity of the counter before this step
                mode_nxt = MD_SKIP;
                lo_nxt   = IW'(cnt_r[0]);
              end
              default: begin
                mode_nxt = mode_r;
              end
            endcase
          end
        end
      end
      S_PLAN: begin
        if (plan_go) begin
          sa_nxt = plan_a;
          sb_nxt = plan_b;
          lo_nxt = plan_lo;
          hi_nxt = plan_hi;
        end
      end
      S_SW_RD: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr_a     = sa_r;
        rd_addr_b     = sb_r;
      end
      S_SW_WA: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = sa_r;
        wr_data       = rd_data_b;
      end
      S_SW_WB: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = sb_r;
        wr_data       = rd_data_a;
      end
      S_LX_RD: begin
        mem_ctl.rd_en = 1'b1;
        if (mode_r == MD_LEX_I) begin
          rd_addr_a = AW'(hi_r - IW'(1));
        end else begin
          rd_addr_a = AW'(lo_r - IW'(1));
        end
        rd_addr_b = AW'(hi_r);
      end
      S_LX_CMP: begin
        if (mode_r == MD_LEX_I) begin
          if (cmp_hit) begin
            // pivot found at i-1: keep i in lo, scan j down from the end
            mode_nxt = MD_LEX_J;
            lo_nxt   = hi_r;
            hi_nxt   = n_r - IW'(1);
          end else if (hi_r == IW'(1)) begin
            // no pivot: wrap by reversing the whole arrangement
            mode_nxt = MD_REV;
            lo_nxt   = '0;
            hi_nxt   = n_r;
          end else begin
            hi_nxt = hi_r - IW'(1);
          end
        end else begin
          if (cmp_hit) begin
            sa_nxt   = AW'(lo_r - IW'(1));
            sb_nxt   = AW'(hi_r);
            mode_nxt = MD_REV;
            hi_nxt   = n_r;
          end else begin
            hi_nxt = hi_r - IW'(1);
          end
        end
      end
      S_EMIT_RD0: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr_a     = '0;
        k_nxt         = '0;
      end
      S_EMIT: begin
        if (out_load) begin
          // prefetch the next element; read data holds while stalled
          k_nxt         = k_r + IW'(1);
          mem_ctl.rd_en = 1'b1;
          rd_addr_a     = AW'(k_r + IW'(1));
        end
      end
      default: begin
        mem_ctl = '0;
      end
    endcase

    // Any write to a listed register restarts the generator
    if (cfg_we) begin
      if (cfg_index == CFG_KIND) begin
        kind_nxt      = pse_kind_t'(cfg_wdata[KIND_W-1:0]);
        mem_ctl.clear = 1'b1;
        cnt_nxt       = '0;
      end else if (cfg_index == CFG_LEN) begin
        len_nxt       = cfg_wdata[LEN_W-1:0];
        mem_ctl.clear = 1'b1;
        cnt_nxt       = '0;
      end
    end
  end

  // Output register: load on a free slot, drop valid once transferred
  assign elem_wide = EXW'(rd_data_a);
  assign pos_wide  = PXW'(k_r);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_pos_nxt   = out_pos_r;
    out_elem_nxt  = out_elem_r;
    out_last_nxt  = out_last_r;
    out_cnt_nxt   = out_cnt_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_pos_nxt   = pos_wide[OUT_IDX_W-1:0];
      out_elem_nxt  = elem_wide[OUT_IDX_W-1:0];
      out_last_nxt  = last_now;
      out_cnt_nxt   = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= KIND_HOLD;
      len_r       <= LEN_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    n_r        <= n_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    k_r        <= k_nxt;
    sa_r       <= sa_nxt;
    sb_r       <= sb_nxt;
    dir_r      <= dir_nxt;
    out_pos_r  <= out_pos_nxt;
    out_elem_r <= out_elem_nxt;
    out_last_r <= out_last_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_position      = out_pos_r;
  assign out_element_value = out_elem_r;
  assign out_last_element  = out_last_r;
  assign out_step_count    = out_cnt_r;

  // Every accepted item starts work, so the input side closes right away
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("idle right after an input transfer");

  // Swap addresses stay inside the arrangement in use
  a_swap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SW_RD) |-> ((IW'(sa_r) < n_r) && (IW'(sb_r) < n_r)))
    else $error("swap address beyond arrangement length");

  // The successor scan never passes the pivot's right neighbor
  a_lex_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_LX_CMP) && (mode_r == MD_LEX_J)) |-> (hi_r >= lo_r))
    else $error("successor scan ran below the pivot");

  // Lexicographic previous leaves the step counter untouched
  a_prev_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_restart && (kind_r == KIND_LEX_PREV) && !cfg_we)
      |=> $stable(cnt_r))
    else $error("step counter moved on a previous step");

endmodule

// File: verif/permutation_step_engine_top_tb.sv
`timescale 1ns / 1ps

module permutation_step_engine_top_tb;
  import pse_pkg::*;

  // Arrangement capacity of the block as instantiated (default MAX_LEN)
  localparam int LEN_CAP = 16;
  localparam int RANDOM_ITEMS = 250;
  localparam logic [63:0] ASCENDING = 64'hFEDC_BA98_7654_3210;

  // Indexes past the end of the register list: writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_restart = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_IDX_W-1:0]  out_position;
  logic [OUT_IDX_W-1:0]  out_element_value;
  logic                  out_last_element;
  logic [CNT_W-1:0]      out_step_count;

  permutation_step_engine_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_position      (out_position),
    .out_element_value (out_element_value),
    .out_last_element  (out_last_element),
    .out_step_count    (out_step_count)
  );

  always #4 clk = ~clk;

  // Hard stop in case the block hangs; far above the slowest legal run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Arrangement predictor: its own copy of the registers, the permutation and
  // the step counter, updated on every accepted input and kind or length write.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [OUT_IDX_W-1:0] pos;
    logic [OUT_IDX_W-1:0] value;
    logic                 last;
    logic [CNT_W-1:0]     count;
  } arr_elem_t;

  arr_elem_t                    elems_due[$];
  logic [LEN_CAP-1:0][3:0]      arrangement;
  logic [CNT_W-1:0]             step_total;
  pse_kind_t                    kind_sel;
  logic [LEN_W-1:0]             len_sel;
  int                           faults = 0;
  bit                           quiet = 1'b0;

  // Length in use: zero counts as one, anything past capacity saturates
  function automatic int span();
    if (len_sel == 0) return 1;
    if (len_sel > LEN_CAP) return LEN_CAP;
    return int'(len_sel);
  endfunction

  function automatic void restore_ascending();
    for (int i = 0; i < LEN_CAP; i++) arrangement[i] = 4'(i);
    step_total = '0;
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [3:0] t;
    t = arrangement[a];
    arrangement[a] = arrangement[b];
    arrangement[b] = t;
  endfunction

  function automatic void flip_span(int lo, int hi);
    while (lo + 1 < hi) begin
      hi--;
      swap_slots(lo, hi);
      lo++;
    end
  endfunction

  // Lexicographic successor (fwd) or predecessor; the last one wraps around
  function automatic void lex_walk(int n, bit fwd);
    int i;
    int j;
    if (n < 2) return;
    i = n - 1;
    while (i > 0 && !(fwd ? arrangement[i-1] < arrangement[i]
                          : arrangement[i-1] > arrangement[i]))
      i--;
    if (i == 0) begin
      flip_span(0, n);
      return;
    end
    j = n - 1;
    while (fwd ? !(arrangement[i-1] < arrangement[j]) : !(arrangement[i-1] > arrangement[j]))
      j--;
    swap_slots(i - 1, j);
    flip_span(i, n);
  endfunction

  function automatic void advance_arrangement(bit restart);
    int n;
    int lim;
    logic [3:0] t;
    n = span();
    lim = n - (n % 2);
    if (restart) begin
      restore_ascending();
      return;
    end
    case (kind_sel)
      KIND_LEX_NEXT: lex_walk(n, 1'b1);
      KIND_LEX_PREV: begin
        // previous leaves the counter alone
        lex_walk(n, 1'b0);
        return;
      end
      KIND_ROT_RIGHT: begin
        t = arrangement[n-1];
        for (int i = n - 1; i > 0; i--) arrangement[i] = arrangement[i-1];
        arrangement[0] = t;
      end
      KIND_ROT_LEFT: begin
        t = arrangement[0];
        for (int i = 0; i + 1 < n; i++) arrangement[i] = arrangement[i+1];
        arrangement[n-1] = t;
      end
      KIND_REVERSE: flip_span(0, n);
      KIND_SWAP_PAIRS: for (int i = 0; i < lim; i += 2) swap_slots(i, i + 1);
      // start at the counter's parity; an odd start on even n wraps to slot 0
      KIND_SKIP: for (int i = int'(step_total[0]); i < lim; i += 2) swap_slots(i, (i + 1) % n);
      default: ;
    endcase
    step_total++;
  endfunction

  function automatic void queue_arrangement(logic [63:0] vals, int n, logic [CNT_W-1:0] count);
    for (int k = 0; k < n; k++)
      elems_due.push_back('{pos: 4'(k), value: vals[4*k +: 4], last: (k == n - 1),
                            count: count});
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Every task starts and ends on a falling edge; the caller
  // decides at that edge whether valid stays up for the next transfer.
  // ---------------------------------------------------------------------------
  function automatic int idle_draw();
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  // Present one item, wait for the transfer, then predict its arrangement.
  // A typed expectation replaces the predicted one for directed rows.
  task automatic push_input(bit restart, bit typed, logic [63:0] vals, int n,
                            logic [CNT_W-1:0] count);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_arrangement(restart);
    if (typed) queue_arrangement(vals, n, count);
    else queue_arrangement(arrangement, span(), step_total);
    @(negedge clk);
  endtask

  // Write one register once the block has drained every element
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (elems_due.size() != 0) @(negedge clk);
    // let the block settle after streaming its last element
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_KIND: begin
        kind_sel = pse_kind_t'(data[KIND_W-1:0]);
        restore_ascending();
      end
      CFG_LEN: begin
        len_sel = data;
        restore_ascending();
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed script. Typed rows carry an arrangement readable straight off the
  // rules (nibble k holds the element at position k); other rows are predicted.
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_WRITE, ROW_ITEM} row_op_t;

  typedef struct packed {
    row_op_t               op;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  restart;
    logic                  typed;
    logic [63:0]           vals;
    logic [LEN_W-1:0]      len;
    logic [CNT_W-1:0]      count;
  } script_row_t;

  script_row_t script[$] = '{
    // out of reset: restart, then hold
    '{ROW_ITEM,  '0, '0, 1'b1, 1'b1, ASCENDING, 5'd16, 16'd0},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b1, ASCENDING, 5'd16, 16'd1},
    // full-length reverse
    '{ROW_WRITE, CFG_KIND, 5'(KIND_REVERSE), 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b1, 64'h0123_4567_89AB_CDEF, 5'd16, 16'd1},
    // length zero behaves as length one; a single element never moves
    '{ROW_WRITE, CFG_LEN, 5'd0, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b1, 64'h0, 5'd1, 16'd1},
    // oversized length saturates
    '{ROW_WRITE, CFG_LEN, 5'd31, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_WRITE, CFG_KIND, 5'(KIND_LEX_NEXT), 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b0, '0, '0, '0},
    // previous from ascending wraps to descending, counter stays; upper data
    // bits of the kind write are dropped
    '{ROW_WRITE, CFG_LEN, 5'd3, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_WRITE, CFG_KIND, {2'b11, KIND_LEX_PREV}, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b1, 64'h012, 5'd3, 16'd0},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_WRITE, CFG_LEN, 5'd4, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_WRITE, CFG_KIND, 5'(KIND_ROT_RIGHT), 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b1, 64'h2103, 5'd4, 16'd1},
    '{ROW_WRITE, CFG_KIND, 5'(KIND_ROT_LEFT), 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b1, 64'h0321, 5'd4, 16'd1},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b0, '0, '0, '0},
    // odd length: the tail element stays put
    '{ROW_WRITE, CFG_LEN, 5'd5, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_WRITE, CFG_KIND, 5'(KIND_SWAP_PAIRS), 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b1, 64'h42301, 5'd5, 16'd1},
    '{ROW_WRITE, CFG_KIND, 5'(KIND_SKIP), 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b1, 64'h42301, 5'd5, 16'd1},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b0, '0, '0, '0},
    // even length, odd parity: last pair wraps to slot 0
    '{ROW_WRITE, CFG_LEN, 5'd4, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b0, '0, '0, '0},
    // writes past the register list change nothing, not even a restart
    '{ROW_WRITE, CFG_SPARE_A, 5'd31, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_WRITE, CFG_SPARE_B, 5'd0, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b1, 1'b1, 64'h3210, 5'd4, 16'd0},
    // next from descending wraps to ascending
    '{ROW_WRITE, CFG_LEN, 5'd2, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_WRITE, CFG_KIND, 5'(KIND_LEX_NEXT), 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b1, 64'h01, 5'd2, 16'd1},
    '{ROW_ITEM,  '0, '0, 1'b0, 1'b1, 64'h10, 5'd2, 16'd2}
  };

  // Pick a length: mostly in range, with zero, full and oversized mixed in
  function automatic logic [CFG_DATA_W-1:0] draw_length();
    case ($urandom_range(0, 9))
      0:       return 5'd0;
      1:       return 5'($urandom_range(17, 31));
      2:       return 5'(LEN_CAP);
      default: return 5'($urandom_range(1, 16));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed script, then random phases. Each phase
  // rewrites the registers while idle and runs a burst of advance items with
  // an occasional restart.
  // ---------------------------------------------------------------------------
  initial begin
    int sent;
    int burst;
    logic [CFG_DATA_W-1:0] kind_word;
    kind_sel = KIND_HOLD;
    len_sel  = LEN_RESET;
    restore_ascending();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[r]) begin
      if (script[r].op == ROW_WRITE) write_register(script[r].idx, script[r].data);
      else push_input(script[r].restart, script[r].typed, script[r].vals,
                      int'(script[r].len), script[r].count);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind_word = {2'($urandom_range(0, 3)), 3'($urandom_range(0, 7))};
      case ($urandom_range(0, 3))
        0: write_register(CFG_KIND, kind_word);
        1: write_register(CFG_LEN, draw_length());
        2: begin
          write_register(CFG_LEN, draw_length());
          write_register(CFG_KIND, kind_word);
        end
        default: begin
          write_register(CFG_KIND, kind_word);
          write_register(CFG_LEN, draw_length());
        end
      endcase
      if ($urandom_range(0, 4) == 0)
        write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                       5'($urandom_range(0, 31)));
      // some phases run with no idling on either side
      quiet = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(4, 24);
      repeat (burst) begin
        push_input($urandom_range(0, 15) == 0, 1'b0, '0, 0, '0);
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (elems_due.size() != 0) @(posedge clk);
    // catch anything extra the block might still stream out
    repeat (200) @(posedge clk);
    if (faults == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: stall for a random number of cycles before each transfer.
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = idle_draw();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // Compare each element transfer against the oldest pending expectation
  always @(posedge clk) begin : check_elem
    arr_elem_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (elems_due.size() == 0) begin
        $error("unexpected element: position %0d value %0d", out_position,
               out_element_value);
        faults++;
      end else begin
        want = elems_due.pop_front();
        if (out_position !== want.pos) begin
          $error("position: expected %0d, got %0d", want.pos, out_position);
          faults++;
        end
        if (out_element_value !== want.value) begin
          $error("element_value: expected %0d, got %0d", want.value, out_element_value);
          faults++;
        end
        if (out_last_element !== want.last) begin
          $error("last_element: expected %0d, got %0d", want.last, out_last_element);
          faults++;
        end
        if (out_step_count !== want.count) begin
          $error("step_count: expected %0d, got %0d", want.count, out_step_count);
          faults++;
        end
      end
    end
  end

endmodule
